FILE: src/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ENTRY_W = 5;
  localparam int unsigned STAT_W  = 2;

  // Operation codes carried by the kind field; unused codes behave as a peek
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK       = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One result item
  typedef struct packed {
    logic signed [WORD_W-1:0] popped;
    logic signed [WORD_W-1:0] first_word;
    logic signed [WORD_W-1:0] last_word;
    logic [ENTRY_W-1:0]       entries;
    status_e                  status;
  } result_t;

endpackage

FILE: src/deq_core.sv
// Queue state, word store and end-word caches; computes one result per transfer.
module deq_core import deq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     acc_i,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic signed [WORD_W-1:0] value_i,
  output result_t                  res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
    return (x == LAST_IDX) ? '0 : x + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
    return (x == '0) ? LAST_IDX : x - AW'(1);
  endfunction

  // Word store, no reset
  logic [WORD_W-1:0] mem_q [DEPTH];

  // Indices and count
  logic [AW-1:0] front_q, front_d, back_q, back_d;
  logic [CW-1:0] count_q, count_d;

  // Cached words: f0 = store[front], f1 = store[front+1], b0 = store[back], b1 = store[back-1]
  logic signed [WORD_W-1:0] f0_q, f0_d, b0_q, b0_d, f1_q, f1_d, b1_q, b1_d;
  logic signed [WORD_W-1:0] frd_q, brd_q, f1_cur, b1_cur;
  logic fsel_q, fsel_d, bsel_q, bsel_d;

  logic              do_write, ld_frd, ld_brd, is_empty, is_full;
  logic [AW-1:0]     wr_addr, rd_f_addr, rd_b_addr;
  logic signed [WORD_W-1:0] popped;
  status_e           status;
  logic [CW+ENTRY_W-1:0] cnt_ext;

  // Second-from-end words come from the read register right after a pop
  assign f1_cur    = fsel_q ? frd_q : f1_q;
  assign b1_cur    = bsel_q ? brd_q : b1_q;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_FULL);
  assign rd_f_addr = idx_inc(idx_inc(front_q));
  assign rd_b_addr = idx_dec(idx_dec(back_q));

  // Operation decode and next state
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    f0_d     = f0_q;
    b0_d     = b0_q;
    f1_d     = f1_q;
    b1_d     = b1_q;
    fsel_d   = fsel_q;
    bsel_d   = bsel_q;
    do_write = 1'b0;
    wr_addr  = front_q;
    ld_frd   = 1'b0;
    ld_brd   = 1'b0;
    popped   = '0;
    status   = ST_OK;
    case (kind_e'(kind_i))
      KIND_PUSH_FRONT: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          front_d  = idx_dec(front_q);
          count_d  = count_q + CW'(1);
          do_write = 1'b1;
          wr_addr  = idx_dec(front_q);
          f0_d     = value_i;
          f1_d     = f0_q;
          fsel_d   = 1'b0;
          if (is_empty) b0_d = value_i;
          if (count_q == CNT_ONE) begin
            b1_d   = value_i;
            bsel_d = 1'b0;
          end
        end
      end
      KIND_PUSH_BACK: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          back_d   = idx_inc(back_q);
          count_d  = count_q + CW'(1);
          do_write = 1'b1;
          wr_addr  = idx_inc(back_q);
          b0_d     = value_i;
          b1_d     = b0_q;
          bsel_d   = 1'b0;
          if (is_empty) f0_d = value_i;
          if (count_q == CNT_ONE) begin
            f1_d   = value_i;
            fsel_d = 1'b0;
          end
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          popped  = f0_q;
          front_d = idx_inc(front_q);
          count_d = count_q - CW'(1);
          f0_d    = f1_cur;
          fsel_d  = 1'b1;
          ld_frd  = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          popped  = b0_q;
          back_d  = idx_dec(back_q);
          count_d = count_q - CW'(1);
          b0_d    = b1_cur;
          bsel_d  = 1'b1;
          ld_brd  = 1'b1;
        end
      end
      default: begin
        if (is_empty) status = ST_EMPTY;
      end
    endcase
  end

  // Result of this transfer
  assign cnt_ext = {{ENTRY_W{1'b0}}, count_d};
  always_comb begin
    res_o.popped     = popped;
    res_o.first_word = (count_d != '0) ? f0_d : '0;
    res_o.last_word  = (count_d != '0) ? b0_d : '0;
    res_o.entries    = cnt_ext[ENTRY_W-1:0];
    res_o.status     = status;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= LAST_IDX;
      count_q <= '0;
      fsel_q  <= 1'b0;
      bsel_q  <= 1'b0;
    end else if (acc_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      fsel_q  <= fsel_d;
      bsel_q  <= bsel_d;
    end
  end

  // End-word caches
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      f0_q <= f0_d;
      b0_q <= b0_d;
      f1_q <= f1_d;
      b1_q <= b1_d;
    end
  end

  // Store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (acc_i && do_write) mem_q[wr_addr] <= value_i;
    if (acc_i && ld_frd) frd_q <= mem_q[rd_f_addr];
    if (acc_i && ld_brd) brd_q <= mem_q[rd_b_addr];
  end

endmodule

FILE: src/deq_obuf.sv
// Two-entry result buffer between the queue logic and the output channel.
module deq_obuf import deq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t data_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot1_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = slot0_q;

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Slot moves: head refills from the second slot or straight from the input
  always_ff @(posedge clk_i) begin
    if (pop && full_o) begin
      slot0_q <= slot1_q;
    end else if (push_i && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
      slot0_q <= data_i;
    end
    if (push_i && (cnt_q == 2'd1) && !pop) slot1_q <= data_i;
  end

endmodule

FILE: src/double_ended_queue.sv
// Bounded double-ended queue of signed words, top level.
// Each result is registered in the result buffer before it reaches the output.
// One operation per cycle unless stalled; each touches only cached end words, one
// store write port and two registered read ports that refill the second-from-end
// words. A two-entry result buffer keeps input transfers going while a result waits.
// Reset clears indices, count and result buffer; the word store is not cleared.
module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] popped_o,
  output logic signed [WORD_W-1:0] first_word_o,
  output logic signed [WORD_W-1:0] last_word_o,
  output logic [ENTRY_W-1:0]       entries_o,
  output logic [STAT_W-1:0]        status_o
);

  logic    in_acc;
  result_t res, res_out;

  assign in_acc = in_valid_i && !in_stall_o;

  // Queue state and per-transfer result
  deq_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .kind_i (kind_i),
    .value_i(value_i),
    .res_o  (res)
  );

  // Result buffer
  deq_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_acc),
    .data_i (res),
    .full_o (in_stall_o),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (res_out)
  );

  assign popped_o     = res_out.popped;
  assign first_word_o = res_out.first_word;
  assign last_word_o  = res_out.last_word;
  assign entries_o    = res_out.entries;
  assign status_o     = res_out.status;

endmodule

FILE: src/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
module deq_checker import deq_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [WORD_W-1:0] popped_o,
  input logic signed [WORD_W-1:0] first_word_o,
  input logic signed [WORD_W-1:0] last_word_o,
  input logic [ENTRY_W-1:0]       entries_o,
  input logic [STAT_W-1:0]        status_o
);

  // Input back-pressure only when results are waiting
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // An empty report carries an empty queue and no words
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |->
      ((entries_o == '0) && (popped_o == '0) && (first_word_o == '0) &&
       (last_word_o == '0)))
    else $error("empty status with non-empty result fields");

  // A dropped push removes nothing
  a_full_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (popped_o == '0))
    else $error("full status with popped word");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(popped_o) && $stable(first_word_o) &&
       $stable(last_word_o) && $stable(entries_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
